// ----- hdl/ogbf_pkg.sv -----
// Shared types and constants for the occupancy grid Bayes fusion block.
`timescale 1ns / 1ps
`default_nettype none
package ogbf_pkg;

  localparam int PROB_W = 16;
  localparam int PROD_W = 2 * (PROB_W + 1);
  localparam int DEN_W  = 2 * PROB_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Probability constants in Q0.16 (one is 17 bits wide)
  localparam logic [PROB_W-1:0] PROB_HALF = 16'h8000;
  localparam logic [PROB_W:0]   PROB_ONE  = 17'h10000;

  // Request commands
  localparam logic CMD_FUSE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_WIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_FLOOR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_CEILING = 2'd3;

  // Configuration reset values
  localparam logic [7:0]        RST_CELLS_WIDE   = 8'd100;
  localparam logic [7:0]        RST_CELLS_HIGH   = 8'd100;
  localparam logic [PROB_W-1:0] RST_PROB_FLOOR   = 16'd655;
  localparam logic [PROB_W-1:0] RST_PROB_CEILING = 16'd64880;

  // Divider launch: numerator is below the denominator by construction
  typedef struct packed {
    logic                  start;
    logic [2*PROB_W-1:0]   num;
    logic [DEN_W-1:0]      den;
  } div_req_t;

endpackage
`default_nettype wire

// ----- hdl/ogbf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ogbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/ogbf_div.sv -----
// Restoring divider producing a 16-bit fractional quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ogbf_div
  import ogbf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_req_t          req,
  output logic                   done,
  output logic [PROB_W-1:0]      quo
);

  localparam int CNT_W = $clog2(PROB_W);

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic                zero_r, zero_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [PROB_W-1:0]   quo_r, quo_nxt;
  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      rem_diff;

  // Shift remainder and trial subtract
  always_comb begin
    rem_sh   = {rem_r, 1'b0};
    rem_diff = rem_sh - {1'b0, den_r};
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      // Load operands
      run_nxt  = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
      zero_nxt = (req.den == '0);
      quo_nxt  = '0;
    end else if (run_r) begin
      // Develop one quotient bit
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_diff[DEN_W-1:0];
        quo_nxt = {quo_r[PROB_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        quo_nxt = {quo_r[PROB_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PROB_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= zero_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
  end

  // Zero denominator yields zero
  assign done = done_r;
  assign quo  = zero_r ? '0 : quo_r;

endmodule
`default_nettype wire

// ----- hdl/occupancy_grid_bayes_fuse_unit.sv -----
// Occupancy grid Bayes fusion unit: sequencer, shared multiplier, grid RAM and divider.
// An out-of-range request goes straight to the result state, a read via the RAM read
// state, a fuse via RAM read, multiply states, divider launch and bit-serial divider. busy
// stays high until out_valid rises, and start is taken again during the out_valid cycle.
// Reset is synchronous, active low; it then sweeps all GRID_DIM*GRID_DIM grid RAM cells
// to one half, one cell per clock, with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module occupancy_grid_bayes_fuse_unit
  import ogbf_pkg::*;
#(
  parameter int GRID_DIM       = 128,
  parameter int OCCUPIED_SCALE = 254
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_command,
  input  wire logic [6:0]            in_cell_x,
  input  wire logic [6:0]            in_cell_y,
  input  wire logic [PROB_W-1:0]     in_likelihood,
  output logic                       out_valid,
  output logic                       out_in_range,
  output logic [PROB_W-1:0]          out_cell_prob,
  output logic [7:0]                 out_cell_byte
);

  localparam int DEPTH  = GRID_DIM * GRID_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_DIVL = 3'd5;
  localparam logic [2:0] ST_DIVW = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [7:0]          cells_wide_r, cells_high_r;
  logic [PROB_W-1:0]   prob_floor_r, prob_ceiling_r;

  logic                cmd_r, cmd_nxt;
  logic                range_r, range_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [PROB_W-1:0]   lik_r, lik_nxt;
  logic [PROB_W-1:0]   prob_r, prob_nxt;
  logic [2*PROB_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_in_range_r, out_in_range_nxt;
  logic [PROB_W-1:0]   out_cell_prob_r, out_cell_prob_nxt;
  logic [7:0]          out_cell_byte_r, out_cell_byte_nxt;

  logic                accept;
  logic                in_range;
  logic [ADDR_W-1:0]   req_addr;
  logic [PROB_W:0]     mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     byte_sum;
  logic [PROB_W-1:0]   clip_lo, clipped;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [PROB_W-1:0]   ram_wdata, ram_rdata;

  div_req_t            div_req;
  logic                div_done;
  logic [PROB_W-1:0]   div_quo;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Decode cell range and grid address of the incoming request
  assign in_range = ({1'b0, in_cell_x} < cells_wide_r) && ({1'b0, in_cell_y} < cells_high_r) &&
                    (32'(in_cell_x) < GRID_DIM) && (32'(in_cell_y) < GRID_DIM);
  assign req_addr = ADDR_W'(in_cell_y) * ADDR_W'(GRID_DIM) + ADDR_W'(in_cell_x);

  // Shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_MUL1: begin
        mul_a = {1'b0, lik_r};
        mul_b = {1'b0, prob_r};
      end
      ST_MUL2: begin
        mul_a = PROB_ONE - {1'b0, lik_r};
        mul_b = PROB_ONE - {1'b0, prob_r};
      end
      default: begin
        mul_a = {1'b0, prob_r};
        mul_b = (PROB_W + 1)'(OCCUPIED_SCALE);
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign byte_sum = {1'b0, prod} + (PROD_W + 1)'(PROB_HALF);

  // Clip quotient: floor first, ceiling wins
  assign clip_lo = (div_quo < prob_floor_r) ? prob_floor_r : div_quo;
  assign clipped = (clip_lo > prob_ceiling_r) ? prob_ceiling_r : clip_lo;

  // Sequencer
  always_comb begin
    state_nxt         = state_r;
    clr_cnt_nxt       = clr_cnt_r;
    cmd_nxt           = cmd_r;
    range_nxt         = range_r;
    addr_nxt          = addr_r;
    lik_nxt           = lik_r;
    prob_nxt          = prob_r;
    num_nxt           = num_r;
    den_nxt           = den_r;
    out_valid_nxt     = 1'b0;
    out_in_range_nxt  = out_in_range_r;
    out_cell_prob_nxt = out_cell_prob_r;
    out_cell_byte_nxt = out_cell_byte_r;
    div_req.start     = 1'b0;
    div_req.num       = num_r;
    div_req.den       = den_r;
    ram_we            = 1'b0;
    ram_waddr         = addr_r;
    ram_wdata         = clipped;
    ram_raddr         = (state_r == ST_IDLE) ? req_addr : addr_r;
    case (state_r)
      ST_CLR: begin
        // Sweep grid to one half
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = PROB_HALF;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_command;
          range_nxt = in_range;
          addr_nxt  = req_addr;
          lik_nxt   = in_likelihood;
          if (in_range) begin
            state_nxt = ST_RD;
          end else begin
            prob_nxt  = '0;
            state_nxt = ST_FIN;
          end
        end
      end
      ST_RD: begin
        // Capture stored probability
        prob_nxt  = ram_rdata;
        state_nxt = (cmd_r == CMD_READ) ? ST_FIN : ST_MUL1;
      end
      ST_MUL1: begin
        num_nxt   = prod[2*PROB_W-1:0];
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        den_nxt   = {1'b0, num_r} + prod[DEN_W-1:0];
        state_nxt = ST_DIVL;
      end
      ST_DIVL: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        // Write back clipped result
        if (div_done) begin
          ram_we    = 1'b1;
          prob_nxt  = clipped;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        out_valid_nxt     = 1'b1;
        out_in_range_nxt  = range_r;
        out_cell_prob_nxt = prob_r;
        out_cell_byte_nxt = byte_sum[2*PROB_W-9:PROB_W];
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    range_r         <= range_nxt;
    addr_r          <= addr_nxt;
    lik_r           <= lik_nxt;
    prob_r          <= prob_nxt;
    num_r           <= num_nxt;
    den_r           <= den_nxt;
    out_in_range_r  <= out_in_range_nxt;
    out_cell_prob_r <= out_cell_prob_nxt;
    out_cell_byte_r <= out_cell_byte_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_wide_r   <= RST_CELLS_WIDE;
      cells_high_r   <= RST_CELLS_HIGH;
      prob_floor_r   <= RST_PROB_FLOOR;
      prob_ceiling_r <= RST_PROB_CEILING;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELLS_WIDE:   cells_wide_r   <= cfg_data[7:0];
        CFG_CELLS_HIGH:   cells_high_r   <= cfg_data[7:0];
        CFG_PROB_FLOOR:   prob_floor_r   <= cfg_data;
        CFG_PROB_CEILING: prob_ceiling_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ogbf_ram #(
    .WIDTH (PROB_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ogbf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid     = out_valid_r;
  assign out_in_range  = out_in_range_r;
  assign out_cell_prob = out_cell_prob_r;
  assign out_cell_byte = out_cell_byte_r;

`ifndef SYNTHESIS
  // Result strobe always drops again right after it rises
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for two cycles");

  // Out-of-range request reports all zeros
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> (out_cell_prob == '0) && (out_cell_byte == '0))
    else $error("out-of-range result not zero");

  // Accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request accepted without going busy");

  // Divider finishes only while the sequencer waits for it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVW))
    else $error("divider done outside wait state");
`endif

endmodule
`default_nettype wire
